// ----- src/int32_alu_floor_divide_trap_assert.svh -----
// assertion helpers for the checked integer alu
`ifndef INT32_ALU_FLOOR_DIVIDE_TRAP_ASSERT_SVH
`define INT32_ALU_FLOOR_DIVIDE_TRAP_ASSERT_SVH

`ifndef SYNTHESIS

// consequence must hold whenever the antecedent holds
`define IALU_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition must never be seen
`define IALU_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define IALU_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define IALU_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- src/ialu_pkg.sv -----
package ialu_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_LT  = 3'd4,
        MODE_GT  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_INT  = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [DataW-1:0] operand_a;
        logic signed [DataW-1:0] operand_b;
        logic                    a_is_integer;
        logic                    b_is_integer;
    } t_in;

    typedef struct packed {
        logic signed [DataW-1:0] result_value;
        logic                    result_is_boolean;
        logic [1:0]              status;
    } t_out;

    // travels alongside the divider stages
    typedef struct packed {
        t_out res;
        logic is_div;
        logic neg;
    } t_side;

endpackage

// ----- src/ialu_div_pipe.sv -----
module ialu_div_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  ialu_pkg::t_side            i_side,
    input  logic [ialu_pkg::DataW-1:0] i_n,
    input  logic [ialu_pkg::DataW-1:0] i_d,
    output logic                       o_valid,
    output ialu_pkg::t_side            o_side,
    output logic [ialu_pkg::DataW-1:0] o_q,
    output logic [ialu_pkg::DataW-1:0] o_rem
);
    import ialu_pkg::*;

    // index 0 is the input, index k the output of step k
    logic                 r_v    [0:DataW];
    t_side                r_side [0:DataW];
    logic [DataW-1:0]     r_nq   [0:DataW];
    logic [DataW-1:0]     r_rem  [0:DataW];
    logic [DataW-1:0]     r_d    [0:DataW];

    always_comb begin
        r_v[0]    = i_valid;
        r_side[0] = i_side;
        r_nq[0]   = i_n;
        r_rem[0]  = '0;
        r_d[0]    = i_d;
    end

    for (genvar k = 1; k <= DataW; k++) begin : g_step
        logic [DataW:0]   n_trial;
        logic             n_ge;
        logic [DataW-1:0] n_rem;

        // one restoring step: dividend bits shift out, quotient bits shift in
        always_comb begin
            n_trial = {r_rem[k-1], r_nq[k-1][DataW-1]};
            n_ge    = n_trial >= {1'b0, r_d[k-1]};
            n_rem   = n_ge ? DataW'(n_trial - {1'b0, r_d[k-1]}) : n_trial[DataW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                r_nq[k]   <= {r_nq[k-1][DataW-2:0], n_ge};
                r_rem[k]  <= n_rem;
                r_d[k]    <= r_d[k-1];
            end
        end
    end

    assign o_valid = r_v[DataW];
    assign o_side  = r_side[DataW];
    assign o_q     = r_nq[DataW];
    assign o_rem   = r_rem[DataW];

endmodule

// ----- src/int32_alu_floor_divide_trap.sv -----
// checked 32-bit signed alu: add, subtract, multiply, floor divide (rounding
// toward minus infinity), less-than and greater-than on two signed operands.
// a non-integer operand gives status 1 and value 0, a zero divisor status 2
// and value 0, an arithmetic result outside the signed 32-bit range status 3
// with the low 32 bits of the exact value. modes 6 and 7 return zero, ok.
// every request passes, from acceptance until its response is offered, through
// one operand stage (sum, difference, compares, 32x32 multiply, magnitudes),
// 32 restoring divider steps of one quotient bit each, and one sign-fix and
// output stage. a new request is accepted every cycle; the whole pipe halts
// only while a response is held by a stalled consumer. responses leave in
// request order
module int32_alu_floor_divide_trap (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ialu_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ialu_pkg::t_out o_out_data
);
    import ialu_pkg::*;
    `include "int32_alu_floor_divide_trap_assert.svh"

    // pipe moves whenever the output slot is free or being drained
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // operand stage
    logic signed [DataW:0]     n_sum;
    logic signed [DataW:0]     n_diff;
    logic signed [2*DataW-1:0] n_prod;
    logic                      n_ints;
    t_side                     n_side;
    logic [DataW-1:0]          n_mag_a;
    logic [DataW-1:0]          n_mag_b;

    always_comb begin
        n_sum   = (DataW+1)'(i_in_data.operand_a) + (DataW+1)'(i_in_data.operand_b);
        n_diff  = (DataW+1)'(i_in_data.operand_a) - (DataW+1)'(i_in_data.operand_b);
        n_prod  = i_in_data.operand_a * i_in_data.operand_b;
        n_ints  = i_in_data.a_is_integer && i_in_data.b_is_integer;
        // magnitudes as unsigned, so the most negative value maps to 2^31
        n_mag_a = i_in_data.operand_a[DataW-1] ? DataW'(-i_in_data.operand_a)
                                               : i_in_data.operand_a;
        n_mag_b = i_in_data.operand_b[DataW-1] ? DataW'(-i_in_data.operand_b)
                                               : i_in_data.operand_b;

        n_side.res    = '0;
        n_side.is_div = 1'b0;
        n_side.neg    = i_in_data.operand_a[DataW-1] ^ i_in_data.operand_b[DataW-1];

        if (!n_ints) begin
            n_side.res.status = ST_NOT_INT;
        end else begin
            unique case (i_in_data.mode)
                MODE_ADD: begin
                    n_side.res.result_value = n_sum[DataW-1:0];
                    if (n_sum[DataW] != n_sum[DataW-1]) n_side.res.status = ST_OVERFLOW;
                end
                MODE_SUB: begin
                    n_side.res.result_value = n_diff[DataW-1:0];
                    if (n_diff[DataW] != n_diff[DataW-1]) n_side.res.status = ST_OVERFLOW;
                end
                MODE_MUL: begin
                    n_side.res.result_value = n_prod[DataW-1:0];
                    // upper half must be a pure sign extension
                    if (n_prod[2*DataW-1:DataW-1] != '0 && n_prod[2*DataW-1:DataW-1] != '1)
                        n_side.res.status = ST_OVERFLOW;
                end
                MODE_DIV: begin
                    if (i_in_data.operand_b == '0) n_side.res.status = ST_DIV_ZERO;
                    else n_side.is_div = 1'b1;
                end
                MODE_LT: begin
                    n_side.res.result_value =
                        DataW'(i_in_data.operand_a < i_in_data.operand_b);
                    n_side.res.result_is_boolean = 1'b1;
                end
                MODE_GT: begin
                    n_side.res.result_value =
                        DataW'(i_in_data.operand_a > i_in_data.operand_b);
                    n_side.res.result_is_boolean = 1'b1;
                end
                default: begin
                    // unused modes give zero with status ok
                end
            endcase
        end
    end

    logic             r_p_valid;
    t_side            r_p_side;
    logic [DataW-1:0] r_p_n;
    logic [DataW-1:0] r_p_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= i_in_valid;
        end
        if (w_en) begin
            r_p_side <= n_side;
            r_p_n    <= n_mag_a;
            r_p_d    <= n_mag_b;
        end
    end

    // unsigned quotient and remainder of the magnitudes
    logic             w_d_valid;
    t_side            w_d_side;
    logic [DataW-1:0] w_d_q;
    logic [DataW-1:0] w_d_rem;

    ialu_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_valid),
        .i_side  (r_p_side),
        .i_n     (r_p_n),
        .i_d     (r_p_d),
        .o_valid (w_d_valid),
        .o_side  (w_d_side),
        .o_q     (w_d_q),
        .o_rem   (w_d_rem)
    );

    // sign fix: negate for unlike signs, step down once more on a remainder
    logic signed [DataW:0] n_qs;
    t_out                  n_out;

    always_comb begin
        n_qs  = w_d_side.neg ? (DataW+1)'(-{1'b0, w_d_q} - (DataW+1)'(w_d_rem != '0))
                             : {1'b0, w_d_q};
        n_out = w_d_side.res;
        if (w_d_side.is_div) begin
            n_out.result_value = n_qs[DataW-1:0];
            // only the most negative value over minus one lands here
            n_out.status = (n_qs[DataW] != n_qs[DataW-1]) ? ST_OVERFLOW : ST_OK;
        end
    end

    logic r_out_valid;
    t_out r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
        if (w_en) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a boolean answer is always a clean 0 or 1 with status ok
    `IALU_ASSERT_IMPLY(a_bool_clean, i_clk, i_rst_n,
        o_out_valid && o_out_data.result_is_boolean,
        o_out_data.status == ST_OK && o_out_data.result_value[DataW-1:1] == '0)
    // error statuses other than overflow carry a zero value
    `IALU_ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status == ST_NOT_INT || o_out_data.status == ST_DIV_ZERO),
        o_out_data.result_value == '0 && !o_out_data.result_is_boolean)
    // a stalled output holds the pipe, so nothing new enters
    `IALU_ASSERT_IMPLY(a_stall_holds, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        !o_in_ready)
    // a negative division with an all-ones quotient and a nonzero remainder never reports an error status
    `IALU_ASSERT_NEVER(a_rem_range, i_clk, i_rst_n,
        w_d_valid && w_d_side.is_div && w_d_rem != '0 && w_d_q == '1 && w_d_side.neg
        && w_d_side.res.status != ST_OK)

endmodule

// ----- verif/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ialu_pkg::*;

    localparam int unsigned NumRandom = 1800;
    localparam int unsigned PipeDepth = 34;
    localparam longint unsigned CycleLimit = 400000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_data;

    int32_alu_floor_divide_trap dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one row of the directed table; has_golden marks a hand-typed answer
    typedef struct {
        t_in  req;
        logic has_golden;
        t_out golden;
    } t_row;

    t_out            pending_results[$];
    int unsigned     fail_count;
    longint unsigned cycle_count;
    // idle odds per hundred for the sender and the receiver
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;

    // floor divide at 64 bits, rounding toward minus infinity
    function automatic longint floor_quot(longint num, longint den);
        longint q;
        longint r;
        q = num / den;
        r = num - q * den;
        if (r != 0 && ((r < 0) != (den < 0))) begin
            q = q - 1;
        end
        return q;
    endfunction

    // checked alu outcome of one request
    function automatic t_out alu_outcome(t_in req);
        t_out   res;
        longint a;
        longint b;
        longint exact;
        logic   arith;
        a     = longint'(req.operand_a);
        b     = longint'(req.operand_b);
        exact = 0;
        arith = 1'b0;
        res   = '0;
        res.status = ST_OK;
        if (!req.a_is_integer || !req.b_is_integer) begin
            res.status = ST_NOT_INT;
        end else begin
            case (req.mode)
                MODE_ADD: begin
                    exact = a + b;
                    arith = 1'b1;
                end
                MODE_SUB: begin
                    exact = a - b;
                    arith = 1'b1;
                end
                MODE_MUL: begin
                    exact = a * b;
                    arith = 1'b1;
                end
                MODE_DIV: begin
                    if (b == 0) begin
                        res.status = ST_DIV_ZERO;
                    end else begin
                        exact = floor_quot(a, b);
                        arith = 1'b1;
                    end
                end
                MODE_LT: begin
                    exact = (a < b) ? 1 : 0;
                    res.result_is_boolean = 1'b1;
                end
                MODE_GT: begin
                    exact = (a > b) ? 1 : 0;
                    res.result_is_boolean = 1'b1;
                end
                default: ;
            endcase
            if (arith && (exact < -64'sd2147483648 || exact > 64'sd2147483647)) begin
                res.status = ST_OVERFLOW;
            end
        end
        res.result_value = exact[31:0];
        return res;
    endfunction

    function automatic t_in make_req(logic [2:0] m, logic [31:0] a, logic [31:0] b,
                                     logic ai, logic bi);
        t_in r;
        r.mode         = m;
        r.operand_a    = a;
        r.operand_b    = b;
        r.a_is_integer = ai;
        r.b_is_integer = bi;
        return r;
    endfunction

    // operand biased toward the edges of the signed range
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'($urandom_range(0, 8)) - 32'd4;
            4:       return 32'($urandom_range(0, 65535));
            5:       return -32'($urandom_range(0, 65535));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in random_req();
        t_in r;
        // the unused modes turn up now and then
        if ($urandom_range(0, 19) == 0) begin
            r.mode = 3'($urandom_range(6, 7));
        end else begin
            r.mode = 3'($urandom_range(MODE_ADD, MODE_GT));
        end
        r.operand_a    = pick_operand();
        r.operand_b    = pick_operand();
        r.a_is_integer = ($urandom_range(0, 15) != 0);
        r.b_is_integer = ($urandom_range(0, 15) != 0);
        return r;
    endfunction

    // hand one request to the block and wait for it to be taken
    task automatic send_request(t_in req, logic has_golden, t_out golden);
        logic seen_ready;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        pending_results.push_back(has_golden ? golden : alu_outcome(req));
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        // ready only moves at rising edges, so sample it at the falling edge before
        do begin
            @(negedge i_clk);
            seen_ready = o_in_ready;
            @(posedge i_clk);
        end while (!seen_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // random receiver stall, redrawn every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // response checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response, actual %p", $realtime, o_out_data);
                fail_count = fail_count + 1;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.result_value !== want.result_value) begin
                    $display("%0t: result_value expected %0d actual %0d", $realtime,
                             want.result_value, o_out_data.result_value);
                    fail_count = fail_count + 1;
                end
                if (o_out_data.result_is_boolean !== want.result_is_boolean) begin
                    $display("%0t: result_is_boolean expected %0b actual %0b", $realtime,
                             want.result_is_boolean, o_out_data.result_is_boolean);
                    fail_count = fail_count + 1;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, o_out_data.status);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_out typed(logic [31:0] v, logic is_b, t_status st);
        t_out r;
        r.result_value      = v;
        r.result_is_boolean = is_b;
        r.status            = st;
        return r;
    endfunction

    initial begin
        t_row directed[$];
        t_row row;
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;

        // directed table: extremes, every mode, each special case
        row.has_golden = 1'b1;
        row.req = make_req(MODE_ADD, 32'h7fff_ffff, 32'd1, 1'b1, 1'b1);
        row.golden = typed(32'h8000_0000, 1'b0, ST_OVERFLOW);         directed.push_back(row);
        row.req = make_req(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
        row.golden = typed(32'd0, 1'b0, ST_OVERFLOW);                 directed.push_back(row);
        row.req = make_req(MODE_SUB, 32'h8000_0000, 32'd1, 1'b1, 1'b1);
        row.golden = typed(32'h7fff_ffff, 1'b0, ST_OVERFLOW);         directed.push_back(row);
        row.req = make_req(MODE_SUB, 32'd0, 32'h8000_0000, 1'b1, 1'b1);
        row.golden = typed(32'h8000_0000, 1'b0, ST_OVERFLOW);         directed.push_back(row);
        row.req = make_req(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
        row.golden = typed(32'd0, 1'b0, ST_OVERFLOW);                 directed.push_back(row);
        row.req = make_req(MODE_MUL, 32'hffff_ffff, 32'h8000_0000, 1'b1, 1'b1);
        row.golden = typed(32'h8000_0000, 1'b0, ST_OVERFLOW);         directed.push_back(row);
        // most negative over minus one
        row.req = make_req(MODE_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b1, 1'b1);
        row.golden = typed(32'h8000_0000, 1'b0, ST_OVERFLOW);         directed.push_back(row);
        row.req = make_req(MODE_DIV, 32'd7, 32'd0, 1'b1, 1'b1);
        row.golden = typed(32'd0, 1'b0, ST_DIV_ZERO);                 directed.push_back(row);
        row.req = make_req(MODE_DIV, 32'h8000_0000, 32'd0, 1'b1, 1'b1);
        row.golden = typed(32'd0, 1'b0, ST_DIV_ZERO);                 directed.push_back(row);
        row.req = make_req(MODE_DIV, 32'hffff_ffff, 32'h0, 1'b0, 1'b1);
        row.golden = typed(32'd0, 1'b0, ST_NOT_INT);                  directed.push_back(row);
        row.req = make_req(MODE_LT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
        row.golden = typed(32'd0, 1'b0, ST_NOT_INT);                  directed.push_back(row);
        row.req = make_req(3'd7, 32'h1234, 32'h5, 1'b0, 1'b0);
        row.golden = typed(32'd0, 1'b0, ST_NOT_INT);                  directed.push_back(row);
        row.req = make_req(MODE_LT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
        row.golden = typed(32'd1, 1'b1, ST_OK);                       directed.push_back(row);
        row.req = make_req(MODE_GT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
        row.golden = typed(32'd0, 1'b1, ST_OK);                       directed.push_back(row);
        row.req = make_req(3'd6, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
        row.golden = typed(32'd0, 1'b0, ST_OK);                       directed.push_back(row);
        row.req = make_req(3'd7, 32'h8000_0000, 32'h0, 1'b1, 1'b1);
        row.golden = typed(32'd0, 1'b0, ST_OK);                       directed.push_back(row);
        // rounding toward minus infinity, plus mul, gt and add cases, left to the predictor
        row.has_golden = 1'b0;
        row.req = make_req(MODE_DIV, 32'd7, -32'd2, 1'b1, 1'b1);      directed.push_back(row);
        row.req = make_req(MODE_DIV, -32'd7, 32'd2, 1'b1, 1'b1);      directed.push_back(row);
        row.req = make_req(MODE_DIV, -32'd7, -32'd2, 1'b1, 1'b1);     directed.push_back(row);
        row.req = make_req(MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1);
        directed.push_back(row);
        row.req = make_req(MODE_MUL, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
        directed.push_back(row);
        row.req = make_req(MODE_GT, 32'd5, 32'd5, 1'b1, 1'b1);        directed.push_back(row);
        row.req = make_req(MODE_ADD, 32'hffff_ffff, 32'h8000_0001, 1'b1, 1'b1);
        directed.push_back(row);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_request(directed[k].req, directed[k].has_golden, directed[k].golden);
        end
        drain_results();

        // three phases: two with idling, the last with none
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 29 : 0;
            for (int n = 0; n < NumRandom / 3; n++) begin
                send_request(random_req(), 1'b0, '0);
                // sender holds off until the pipe has emptied
                if (n == 100) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (PipeDepth + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
